// ----- rtl/srfm_pkg.sv -----
// ----------------------------------------------------------------------------
// srfm_pkg
// Shared types, codes and helpers for the slot ring free/used manager.
// ----------------------------------------------------------------------------
package srfm_pkg;

  localparam int unsigned DEF_MAX_SLOTS = 16;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned STAT_W        = 2;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned CFG_W         = 5;
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam int unsigned RING_LIMIT    = 31;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = CFG_W'(16);
  localparam logic             REG_SLOT_COUNT = 1'b0;

  localparam logic [CMD_W-1:0] CMD_GET_FREE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_USED = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET_USED = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ORDER = 2'd2;

  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_FREE = 2'd1;
  localparam logic [1:0] SEL_USED = 2'd2;

  typedef struct packed {
    logic              load;
    logic              cfg_load;
    logic              take_free;
    logic              mark_used;
    logic              take_used;
    logic              release_slot;
    logic              clear;
    logic [STAT_W-1:0] status;
    logic [1:0]        slot_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic free_empty;
    logic used_empty;
    logic mark_match;
    logic ring_full;
    logic release_match;
  } dp_stat_t;

  function automatic logic [CFG_W-1:0] ring_size(input logic [CFG_W-1:0] cnt,
                                                 input int unsigned max_size);
    logic [CFG_W-1:0] lim;
    lim = CFG_W'(max_size);
    if (cnt == '0) begin
      return CFG_W'(1);
    end else if (cnt > lim) begin
      return lim;
    end
    return cnt;
  endfunction

endpackage

// ----- rtl/srfm_ctrl.sv -----
// ----------------------------------------------------------------------------
// srfm_ctrl
// Request handshake and command decode; drives the datapath update strobes.
// ----------------------------------------------------------------------------
module srfm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [srfm_pkg::CMD_W-1:0] command,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       cfg_we,
  input  srfm_pkg::dp_stat_t         dp_stat,
  output srfm_pkg::dp_cmd_t          dp_cmd
);
  import srfm_pkg::*;

  localparam logic S_EMPTY = 1'b0;
  localparam logic S_FULL  = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign out_valid = (state == S_FULL);
  assign in_ready  = (state == S_EMPTY) || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    if (accept) begin
      state_next = S_FULL;
    end else if (out_ready) begin
      state_next = S_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    dp_cmd          = '0;
    dp_cmd.load     = accept;
    dp_cmd.cfg_load = cfg_we;
    dp_cmd.status   = STAT_OK;
    dp_cmd.slot_sel = SEL_ZERO;
    if (accept) begin
      case (command)
        CMD_GET_FREE: begin
          if (dp_stat.free_empty) begin
            dp_cmd.status = STAT_NONE;
          end else begin
            dp_cmd.take_free = 1'b1;
            dp_cmd.slot_sel  = SEL_FREE;
          end
        end
        CMD_SET_USED: begin
          if (!dp_stat.mark_match || dp_stat.ring_full) begin
            dp_cmd.status = STAT_ORDER;
          end else begin
            dp_cmd.mark_used = 1'b1;
          end
        end
        CMD_GET_USED: begin
          if (dp_stat.used_empty) begin
            dp_cmd.status = STAT_NONE;
          end else begin
            dp_cmd.take_used = 1'b1;
            dp_cmd.slot_sel  = SEL_USED;
          end
        end
        CMD_RELEASE: begin
          if (!dp_stat.release_match || dp_stat.used_empty) begin
            dp_cmd.status = STAT_ORDER;
          end else begin
            dp_cmd.release_slot = 1'b1;
          end
        end
        CMD_CLEAR: begin
          dp_cmd.clear = 1'b1;
        end
        default: begin
          dp_cmd.status = STAT_OK;
        end
      endcase
    end
  end

endmodule

// ----- rtl/srfm_datapath.sv -----
// ----------------------------------------------------------------------------
// srfm_datapath
// Ring pointers, free and used counters, size register and result register.
// ----------------------------------------------------------------------------
module srfm_datapath #(
  parameter int unsigned MAX_SLOTS = srfm_pkg::DEF_MAX_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [srfm_pkg::SLOT_W-1:0] slot_index,
  input  logic [srfm_pkg::CFG_W-1:0]  cfg_wdata,
  input  srfm_pkg::dp_cmd_t           dp_cmd,
  output srfm_pkg::dp_stat_t          dp_stat,
  output logic [srfm_pkg::CFG_W-1:0]  slot_count,
  output logic [srfm_pkg::STAT_W-1:0] status,
  output logic [srfm_pkg::SLOT_W-1:0] slot_out,
  output logic [srfm_pkg::COUNT_W-1:0] free_count,
  output logic [srfm_pkg::COUNT_W-1:0] used_count
);
  import srfm_pkg::*;

  localparam int unsigned RING_MAX = (MAX_SLOTS < RING_LIMIT) ? MAX_SLOTS : RING_LIMIT;
  localparam int unsigned PTR_W    = $clog2(RING_MAX);
  localparam int unsigned CNT_W    = $clog2(RING_MAX + 1);

  logic [CNT_W-1:0] size;
  logic [CNT_W-1:0] size_next;
  logic [CNT_W-1:0] new_size;
  logic [PTR_W-1:0] take_free_ptr, take_free_ptr_next;
  logic [PTR_W-1:0] mark_used_ptr, mark_used_ptr_next;
  logic [PTR_W-1:0] take_used_ptr, take_used_ptr_next;
  logic [PTR_W-1:0] release_ptr, release_ptr_next;
  logic [CNT_W-1:0] free_slots, free_slots_next;
  logic [CNT_W-1:0] used_slots, used_slots_next;
  logic [CFG_W-1:0] idx_ext;
  logic [CNT_W:0]   fill_sum;
  logic [PTR_W-1:0] slot_pick;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] sz);
    logic [CNT_W-1:0] q;
    q = CNT_W'(p) + CNT_W'(1);
    return (q >= sz) ? '0 : PTR_W'(q);
  endfunction

  assign new_size = CNT_W'(ring_size(cfg_wdata, RING_MAX));
  assign idx_ext  = CFG_W'(slot_index);
  assign fill_sum = {1'b0, free_slots} + {1'b0, used_slots};

  assign dp_stat.free_empty    = (free_slots == '0);
  assign dp_stat.used_empty    = (used_slots == '0);
  assign dp_stat.mark_match    = (idx_ext == CFG_W'(mark_used_ptr));
  assign dp_stat.ring_full     = (fill_sum >= {1'b0, size});
  assign dp_stat.release_match = (idx_ext == CFG_W'(release_ptr));

  always_comb begin
    size_next          = size;
    take_free_ptr_next = take_free_ptr;
    mark_used_ptr_next = mark_used_ptr;
    take_used_ptr_next = take_used_ptr;
    release_ptr_next   = release_ptr;
    free_slots_next    = free_slots;
    used_slots_next    = used_slots;
    if (dp_cmd.cfg_load || dp_cmd.clear) begin
      if (dp_cmd.cfg_load) begin
        size_next = new_size;
      end
      take_free_ptr_next = '0;
      mark_used_ptr_next = '0;
      take_used_ptr_next = '0;
      release_ptr_next   = '0;
      free_slots_next    = size_next;
      used_slots_next    = '0;
    end else begin
      if (dp_cmd.take_free) begin
        free_slots_next    = free_slots - CNT_W'(1);
        take_free_ptr_next = advance(take_free_ptr, size);
      end
      if (dp_cmd.mark_used) begin
        used_slots_next    = used_slots + CNT_W'(1);
        mark_used_ptr_next = advance(mark_used_ptr, size);
      end
      if (dp_cmd.take_used) begin
        take_used_ptr_next = advance(take_used_ptr, size);
      end
      if (dp_cmd.release_slot) begin
        used_slots_next  = used_slots - CNT_W'(1);
        free_slots_next  = free_slots + CNT_W'(1);
        release_ptr_next = advance(release_ptr, size);
      end
    end
  end

  always_comb begin
    case (dp_cmd.slot_sel)
      SEL_FREE: slot_pick = take_free_ptr;
      SEL_USED: slot_pick = take_used_ptr;
      default:  slot_pick = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= SLOT_COUNT_RST;
      size          <= CNT_W'(ring_size(SLOT_COUNT_RST, RING_MAX));
      take_free_ptr <= '0;
      mark_used_ptr <= '0;
      take_used_ptr <= '0;
      release_ptr   <= '0;
      free_slots    <= CNT_W'(ring_size(SLOT_COUNT_RST, RING_MAX));
      used_slots    <= '0;
    end else begin
      if (dp_cmd.cfg_load) begin
        slot_count <= cfg_wdata;
      end
      size          <= size_next;
      take_free_ptr <= take_free_ptr_next;
      mark_used_ptr <= mark_used_ptr_next;
      take_used_ptr <= take_used_ptr_next;
      release_ptr   <= release_ptr_next;
      free_slots    <= free_slots_next;
      used_slots    <= used_slots_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      status     <= dp_cmd.status;
      slot_out   <= SLOT_W'(slot_pick);
      free_count <= COUNT_W'(free_slots_next);
      used_count <= COUNT_W'(used_slots_next);
    end
  end

endmodule

// ----- rtl/slot_ring_free_used_manager.sv -----
// ----------------------------------------------------------------------------
// slot_ring_free_used_manager
// Free/used slot ring manager with an APB register for the ring size.
// ----------------------------------------------------------------------------
// Each request (get free, set used, get used, release used, clear) is
// decoded against the pointer and counter registers and its result is
// loaded into the output register at the accept edge. A new request
// is taken in the same cycle the pending result is taken, so the block
// sustains one request per cycle when out_ready stays high. Writing
// slot_count (address 0) resizes the ring and clears it at once.
module slot_ring_free_used_manager #(
  parameter int unsigned MAX_SLOTS = srfm_pkg::DEF_MAX_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srfm_pkg::CMD_W-1:0]    command,
  input  logic [srfm_pkg::SLOT_W-1:0]   slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srfm_pkg::STAT_W-1:0]   status,
  output logic [srfm_pkg::SLOT_W-1:0]   slot_out,
  output logic [srfm_pkg::COUNT_W-1:0]  free_count,
  output logic [srfm_pkg::COUNT_W-1:0]  used_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srfm_pkg::PADDR_W-1:0]  paddr,
  input  logic [srfm_pkg::PDATA_W-1:0]  pwdata,
  output logic [srfm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import srfm_pkg::*;

  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  logic             cfg_we;
  logic [CFG_W-1:0] slot_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_SLOT_COUNT);
  assign prdata = (paddr[2] == REG_SLOT_COUNT) ? PDATA_W'(slot_count) : '0;

  srfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  srfm_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .slot_index (slot_index),
    .cfg_wdata  (pwdata[CFG_W-1:0]),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat),
    .slot_count (slot_count),
    .status     (status),
    .slot_out   (slot_out),
    .free_count (free_count),
    .used_count (used_count)
  );

endmodule

// ----- rtl/srfm_checker.sv -----
// ----------------------------------------------------------------------------
// srfm_checker
// Port-level checks on results of the slot ring manager.
// ----------------------------------------------------------------------------
module srfm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [srfm_pkg::CMD_W-1:0]    command,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [srfm_pkg::STAT_W-1:0]   status,
  input logic [srfm_pkg::SLOT_W-1:0]   slot_out,
  input logic [srfm_pkg::COUNT_W-1:0]  free_count,
  input logic [srfm_pkg::COUNT_W-1:0]  used_count
);
  import srfm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_out))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  a_fail_no_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_OK) |-> (slot_out == '0))
    else $error("failed request returned a slot");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_CLEAR)
      |=> (used_count == '0) && (status == STAT_OK) && (free_count != '0))
    else $error("clear left used slots");

  a_bad_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STAT_OK) || (status == STAT_NONE) || (status == STAT_ORDER))
    else $error("undefined status code");

endmodule

bind slot_ring_free_used_manager srfm_checker u_srfm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .command    (command),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .slot_out   (slot_out),
  .free_count (free_count),
  .used_count (used_count)
);

// ----- tb/slot_ring_free_used_manager_tb.sv -----
// ----------------------------------------------------------------------------
// slot_ring_free_used_manager_tb
// Self-checking bench for the slot ring manager. A short table of directed
// requests covers the empty and full ring, out-of-order slots, unknown
// commands and size clamping. Random phases at several ring sizes then drive
// mostly in-order fill and drain traffic. Every result is compared with
// fixed values from its table row or a local model of the pointers and
// counters, with bursty requests and a stalling receiver on the result side.
// ----------------------------------------------------------------------------
module slot_ring_free_used_manager_tb;
  import srfm_pkg::*;

  localparam int unsigned RING_MAX        = DEF_MAX_SLOTS;
  localparam int unsigned NUM_PHASES      = 10;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned TAIL_CYCLES     = 8;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  localparam logic [PADDR_W-1:0] ADDR_SLOT_COUNT = PADDR_W'(4 * REG_SLOT_COUNT);
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED   = PADDR_W'(4);

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] free;
    logic [COUNT_W-1:0] used;
  } ring_result_t;

  typedef struct packed {
    bit                 is_cfg;
    logic [PADDR_W-1:0] addr;
    logic [PDATA_W-1:0] value;
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  idx;
    bit                 use_fixed;
    ring_result_t       fixed;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    command;
  logic [SLOT_W-1:0]   slot_index;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [SLOT_W-1:0]   slot_out;
  logic [COUNT_W-1:0]  free_count;
  logic [COUNT_W-1:0]  used_count;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic [CFG_W-1:0]    size_reg;
  logic [SLOT_W-1:0]   nxt_take;
  logic [SLOT_W-1:0]   nxt_mark;
  logic [SLOT_W-1:0]   nxt_get;
  logic [SLOT_W-1:0]   nxt_rel;
  int unsigned         n_free;
  int unsigned         n_used;

  ring_result_t        pending_results[$];
  stim_row_t           directed_rows[$];
  ring_result_t        want;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  logic [15:0]         rx_tick = '0;

  slot_ring_free_used_manager i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .slot_index (slot_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .slot_out   (slot_out),
    .free_count (free_count),
    .used_count (used_count),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned ring_len();
    if (size_reg == '0) begin
      return 1;
    end
    if (size_reg > RING_MAX) begin
      return RING_MAX;
    end
    return int'(size_reg);
  endfunction

  function automatic logic [SLOT_W-1:0] step_ptr(input logic [SLOT_W-1:0] p);
    if (int'(p) + 1 >= ring_len()) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic void ring_clear();
    nxt_take = '0;
    nxt_mark = '0;
    nxt_get  = '0;
    nxt_rel  = '0;
    n_free   = ring_len();
    n_used   = 0;
  endfunction

  function automatic void ring_predict(input logic [CMD_W-1:0] cmd,
                                       input logic [SLOT_W-1:0] idx,
                                       output ring_result_t res);
    res = '0;
    res.status = STAT_OK;
    case (cmd)
      CMD_GET_FREE: begin
        if (n_free == 0) begin
          res.status = STAT_NONE;
        end else begin
          res.slot = nxt_take;
          n_free   = n_free - 1;
          nxt_take = step_ptr(nxt_take);
        end
      end
      CMD_SET_USED: begin
        if (idx != nxt_mark || n_free + n_used >= ring_len()) begin
          res.status = STAT_ORDER;
        end else begin
          n_used   = n_used + 1;
          nxt_mark = step_ptr(nxt_mark);
        end
      end
      CMD_GET_USED: begin
        if (n_used == 0) begin
          res.status = STAT_NONE;
        end else begin
          res.slot = nxt_get;
          nxt_get  = step_ptr(nxt_get);
        end
      end
      CMD_RELEASE: begin
        if (idx != nxt_rel || n_used == 0) begin
          res.status = STAT_ORDER;
        end else begin
          n_used  = n_used - 1;
          n_free  = n_free + 1;
          nxt_rel = step_ptr(nxt_rel);
        end
      end
      CMD_CLEAR: begin
        ring_clear();
      end
      default: begin
      end
    endcase
    res.free = COUNT_W'(n_free);
    res.used = COUNT_W'(n_used);
  endfunction

  function automatic void pick_request(input bit fill, output logic [CMD_W-1:0] cmd,
                                       output logic [SLOT_W-1:0] idx);
    int unsigned r;
    r   = $urandom_range(0, 99);
    idx = SLOT_W'($urandom_range(0, 15));
    if (r < (fill ? 35 : 10)) begin
      cmd = CMD_GET_FREE;
    end else if (r < (fill ? 70 : 25)) begin
      cmd = CMD_SET_USED;
      if ($urandom_range(0, 99) < 85) begin
        idx = nxt_mark;
      end
    end else if (r < (fill ? 80 : 45)) begin
      cmd = CMD_GET_USED;
    end else if (r < (fill ? 92 : 90)) begin
      cmd = CMD_RELEASE;
      if ($urandom_range(0, 99) < 85) begin
        idx = nxt_rel;
      end
    end else if (r < 93) begin
      cmd = CMD_CLEAR;
    end else if (r < 96) begin
      cmd = CMD_UNUSED_LO + CMD_W'($urandom_range(0, 2));
    end else begin
      cmd = CMD_W'($urandom_range(0, 7));
    end
  endfunction

  function automatic logic [CFG_W-1:0] phase_size(input int unsigned p);
    case (p)
      0: return CFG_W'(16);
      1: return CFG_W'(1);
      2: return CFG_W'(2);
      3: return CFG_W'(0);
      4: return CFG_W'(31);
      5: return CFG_W'(3);
      6: return CFG_W'(17);
      7: return CFG_W'($urandom_range(1, 16));
      8: return CFG_W'($urandom_range(4, 15));
      default: return CFG_W'(16);
    endcase
  endfunction

  function automatic void add_req(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] idx);
    stim_row_t row;
    row = '0;
    row.cmd = cmd;
    row.idx = idx;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_chk(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] idx,
                                  input logic [STAT_W-1:0] st, input logic [SLOT_W-1:0] sl,
                                  input int unsigned fc, input int unsigned uc);
    stim_row_t row;
    row = '0;
    row.cmd          = cmd;
    row.idx          = idx;
    row.use_fixed    = 1'b1;
    row.fixed.status = st;
    row.fixed.slot   = sl;
    row.fixed.free   = COUNT_W'(fc);
    row.fixed.used   = COUNT_W'(uc);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.addr   = addr;
    row.value  = value;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] idx,
                              input bit use_fixed, input ring_result_t fixed);
    ring_result_t predicted;
    @(negedge clk);
    in_valid   <= 1'b1;
    command    <= cmd;
    slot_index <= idx;
    do @(posedge clk); while (!in_ready);
    ring_predict(cmd, idx, predicted);
    pending_results.push_back(use_fixed ? fixed : predicted);
  endtask

  task automatic hold_idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic settle();
    hold_idle(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_SLOT_COUNT) begin
      size_reg = value[CFG_W-1:0];
      ring_clear();
    end
    @(negedge clk);
    if (addr == ADDR_SLOT_COUNT) begin
      check_field("prdata", int'(value[CFG_W-1:0]), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  always @(negedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    case (rx_tick[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 1) == 0);
      2'd2: out_ready <= (rx_tick[1:0] == 2'd3);
      default: out_ready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d slot %0d", status, slot_out);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status);
        check_field("slot_out", want.slot, slot_out);
        check_field("free_count", want.free, free_count);
        check_field("used_count", want.used, used_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] idx;
    int unsigned       burst_left;
    bit                fill_mode;
    logic [PDATA_W-1:0] cfg_value;

    rst        = 1'b1;
    in_valid   = 1'b0;
    command    = CMD_GET_FREE;
    slot_index = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = ADDR_SLOT_COUNT;
    pwdata     = '0;
    size_reg   = SLOT_COUNT_RST;
    ring_clear();
    burst_left = 0;
    fill_mode  = 1'b0;

    add_chk(CMD_GET_USED, 4'd0, STAT_NONE, 4'd0, 16, 0);
    add_chk(CMD_SET_USED, 4'd0, STAT_ORDER, 4'd0, 16, 0);
    add_chk(CMD_RELEASE, 4'd0, STAT_ORDER, 4'd0, 16, 0);
    add_chk(CMD_GET_FREE, 4'd0, STAT_OK, 4'd0, 15, 0);
    add_chk(CMD_SET_USED, 4'd15, STAT_ORDER, 4'd0, 15, 0);
    add_chk(CMD_SET_USED, 4'd0, STAT_OK, 4'd0, 15, 1);
    add_chk(CMD_GET_USED, 4'd0, STAT_OK, 4'd0, 15, 1);
    add_req(CMD_GET_USED, 4'd0);
    add_chk(CMD_RELEASE, 4'd9, STAT_ORDER, 4'd0, 15, 1);
    add_chk(CMD_RELEASE, 4'd0, STAT_OK, 4'd0, 16, 0);
    add_chk(CMD_UNUSED_LO, 4'd10, STAT_OK, 4'd0, 16, 0);
    add_chk(CMD_UNUSED_HI, 4'd15, STAT_OK, 4'd0, 16, 0);
    add_req(CMD_GET_FREE, 4'd5);
    add_chk(CMD_CLEAR, 4'd0, STAT_OK, 4'd0, 16, 0);
    add_cfg(ADDR_SLOT_COUNT, 32'd1);
    add_chk(CMD_GET_FREE, 4'd0, STAT_OK, 4'd0, 0, 0);
    add_chk(CMD_GET_FREE, 4'd0, STAT_NONE, 4'd0, 0, 0);
    add_chk(CMD_SET_USED, 4'd0, STAT_OK, 4'd0, 0, 1);
    add_chk(CMD_SET_USED, 4'd0, STAT_ORDER, 4'd0, 0, 1);
    add_chk(CMD_GET_USED, 4'd0, STAT_OK, 4'd0, 0, 1);
    add_chk(CMD_RELEASE, 4'd0, STAT_OK, 4'd0, 1, 0);
    add_cfg(ADDR_SLOT_COUNT, 32'd0);
    add_chk(CMD_GET_FREE, 4'd0, STAT_OK, 4'd0, 0, 0);
    add_chk(CMD_GET_FREE, 4'd0, STAT_NONE, 4'd0, 0, 0);
    add_cfg(ADDR_SLOT_COUNT, 32'd31);
    add_chk(CMD_UNUSED_MID, 4'd7, STAT_OK, 4'd0, 16, 0);
    add_cfg(ADDR_UNMAPPED, 32'd2);
    add_chk(CMD_CLEAR, 4'd0, STAT_OK, 4'd0, 16, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        reg_write(directed_rows[i].addr, directed_rows[i].value);
      end else begin
        send_request(directed_rows[i].cmd, directed_rows[i].idx,
                     directed_rows[i].use_fixed, directed_rows[i].fixed);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      cfg_value = PDATA_W'(phase_size(p));
      if (p % 2 == 1) begin
        // upper bits are outside the register and must be dropped
        cfg_value = ($urandom() & 32'hFFFF_FFE0) | cfg_value;
      end
      reg_write(ADDR_SLOT_COUNT, cfg_value);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) begin
          settle();
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          fill_mode  = $urandom_range(0, 1);
          if (p % 2 == 0) begin
            hold_idle($urandom_range(1, 6));
          end
        end
        pick_request(fill_mode, cmd, idx);
        send_request(cmd, idx, 1'b0, '0);
        burst_left--;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- slot_ring_free_used_manager.f -----
rtl/srfm_pkg.sv
rtl/srfm_ctrl.sv
rtl/srfm_datapath.sv
rtl/slot_ring_free_used_manager.sv
rtl/srfm_checker.sv
tb/slot_ring_free_used_manager_tb.sv
